// ===== hw/rtl/rpms_pkg.sv =====
`timescale 1ns / 1ps

package rpms_pkg;

   // tree geometry
   localparam int LEAVES     = 1024;
   localparam int SPAN       = 1 << $clog2(LEAVES);
   localparam int IDX_W      = $clog2(2 * SPAN);
   localparam int DEPTH      = 2 * SPAN;
   localparam int POS_W      = 11;
   localparam int VAL_W      = 30;

   localparam logic [VAL_W:0] MODULUS = 31'd1000000007;

   // reciprocal of the modulus, floor(2^60 / modulus)
   localparam logic [VAL_W:0] BARRETT_MU =
      (VAL_W + 1)'((64'd1 << (2 * VAL_W)) / 64'(MODULUS));

   typedef logic [VAL_W-1:0] val_type;
   typedef logic [POS_W-1:0] pos_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [IDX_W:0]   bound_type;

   // read address select
   typedef enum logic [1:0] {
      RD_LEFT_CHILD,
      RD_RIGHT_CHILD,
      RD_LOW,
      RD_HIGH_DEC
   } rd_sel_type;

   // multiplier operand select
   typedef enum logic {
      MS_CHILDREN,
      MS_ACC
   } mul_src_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_U_WRITE,
      ST_U_RDL,
      ST_U_RDR,
      ST_U_MUL,
      ST_U_WAIT,
      ST_Q_TEST,
      ST_Q_LMUL,
      ST_Q_LWAIT,
      ST_Q_RCHK,
      ST_Q_RMUL,
      ST_Q_RWAIT,
      ST_Q_SHIFT,
      ST_Q_OUT
   } state_type;

   typedef struct packed {
      logic        clr_wr;
      logic        load;
      rd_sel_type  rd_sel;
      logic        cap_opa;
      logic        mul_start;
      mul_src_type mul_src;
      logic        wr_leaf;
      logic        wr_node;
      logic        node_up;
      logic        acc_load;
      logic        l_inc;
      logic        r_dec;
      logic        shift_lr;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic upd_ok;
      logic is_root;
      logic l_lt_r;
      logic l_odd;
      logic r_odd;
      logic mul_done;
   } status_type;

endpackage

// ===== hw/rtl/rpms_modmul.sv =====
`timescale 1ns / 1ps

module rpms_modmul (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rpms_pkg::val_type a,
   input  rpms_pkg::val_type b,
   output logic             done,
   output rpms_pkg::val_type result
);
   import rpms_pkg::*;

   logic [2*VAL_W-1:0]   prod_ff, prod_in;
   logic [2*VAL_W+1:0]   quot_ff, quot_in;
   logic [31:0]          qm_ff, qm_in;
   val_type              res_ff, res_in;
   logic [2:0]           stage_ff, stage_in;
   logic                 done_ff, done_in;

   logic [VAL_W:0]       q1;
   logic [VAL_W:0]       q3;
   logic [31:0]          rem0, rem1, rem2;

   // full product, then quotient estimate by reciprocal multiply, then correction
   always_comb begin
      prod_in  = start ? ((2*VAL_W)'(a) * (2*VAL_W)'(b)) : prod_ff;
      q1       = prod_ff[2*VAL_W-1:VAL_W-1];
      quot_in  = (2*VAL_W+2)'(q1) * (2*VAL_W+2)'(BARRETT_MU);
      q3       = quot_ff[2*VAL_W+1:VAL_W+1];
      qm_in    = 32'(32'(q3) * 32'(MODULUS));
      rem0     = prod_ff[31:0] - qm_ff;
      rem1     = (rem0 >= 32'(MODULUS)) ? rem0 - 32'(MODULUS) : rem0;
      rem2     = (rem1 >= 32'(MODULUS)) ? rem1 - 32'(MODULUS) : rem1;
      res_in   = val_type'(rem2);
      stage_in = {stage_ff[1:0], start};
      done_in  = stage_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      quot_ff <= quot_in;
      qm_ff   <= qm_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== hw/rtl/rpms_datapath.sv =====
`timescale 1ns / 1ps

module rpms_datapath (
   input  logic                clock,
   input  logic                reset,
   input  rpms_pkg::cmd_type    cmd,
   output rpms_pkg::status_type status,
   input  rpms_pkg::pos_type    req_position,
   input  rpms_pkg::val_type    req_new_value,
   input  rpms_pkg::pos_type    req_range_left,
   input  rpms_pkg::pos_type    req_range_right,
   output rpms_pkg::val_type    rsp_product
);
   import rpms_pkg::*;

   val_type   mem [DEPTH];
   val_type   rdata_ff;
   idx_type   raddr;
   idx_type   waddr;
   val_type   wdata;
   logic      wen;

   idx_type   clr_cnt_ff, clr_cnt_in;
   idx_type   node_ff, node_in;
   bound_type l_ff, l_in;
   bound_type r_ff, r_in;
   val_type   acc_ff, acc_in;
   val_type   opa_ff, opa_in;
   val_type   val_ff, val_in;
   val_type   product_ff, product_in;

   logic [VAL_W:0] val_ext;
   val_type   val_red;
   logic [31:0] lo_c, hi_c;
   logic      empty;

   val_type   mul_a, mul_b, mul_res;
   logic      mul_done;

   rpms_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   // request decode: reduce value, clamp range
   always_comb begin
      val_ext = {1'b0, req_new_value};
      val_red = (val_ext >= MODULUS) ? val_type'(val_ext - MODULUS) : req_new_value;
      lo_c    = (req_range_left == '0) ? 32'd1 : 32'(req_range_left);
      hi_c    = (32'(req_range_right) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(req_range_right);
      empty   = lo_c > hi_c;
   end

   // read address
   always_comb begin
      unique case (cmd.rd_sel)
         RD_LEFT_CHILD:  raddr = {node_ff[IDX_W-2:0], 1'b0};
         RD_RIGHT_CHILD: raddr = {node_ff[IDX_W-2:0], 1'b1};
         RD_LOW:         raddr = l_ff[IDX_W-1:0];
         RD_HIGH_DEC:    raddr = idx_type'(r_ff - 1'b1);
         default:        raddr = '0;
      endcase
   end

   // operand select
   always_comb begin
      mul_a = (cmd.mul_src == MS_ACC) ? acc_ff : opa_ff;
      mul_b = rdata_ff;
   end

   // write port
   always_comb begin
      wen   = cmd.clr_wr | cmd.wr_leaf | cmd.wr_node;
      waddr = cmd.clr_wr ? clr_cnt_ff : node_ff;
      wdata = cmd.clr_wr ? val_type'(1) : (cmd.wr_leaf ? val_ff : mul_res);
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // index and accumulator registers
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      node_in    = node_ff;
      l_in       = l_ff;
      r_in       = r_ff;
      acc_in     = acc_ff;
      opa_in     = opa_ff;
      val_in     = val_ff;
      product_in = product_ff;
      if (cmd.clr_wr) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
      if (cmd.load) begin
         val_in  = val_red;
         node_in = idx_type'(32'(SPAN - 1) + 32'(req_position));
         acc_in  = val_type'(1);
         l_in    = empty ? '0 : bound_type'(32'(SPAN - 1) + lo_c);
         r_in    = empty ? '0 : bound_type'(32'(SPAN) + hi_c);
      end
      if (cmd.node_up) begin
         node_in = node_ff >> 1;
      end
      if (cmd.cap_opa) begin
         opa_in = rdata_ff;
      end
      if (cmd.acc_load) begin
         acc_in = mul_res;
      end
      if (cmd.l_inc) begin
         l_in = l_ff + 1'b1;
      end
      if (cmd.r_dec) begin
         r_in = r_ff - 1'b1;
      end
      if (cmd.shift_lr) begin
         l_in = l_ff >> 1;
         r_in = r_ff >> 1;
      end
      if (cmd.out_load) begin
         product_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff    <= node_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      acc_ff     <= acc_in;
      opa_ff     <= opa_in;
      val_ff     <= val_in;
      product_ff <= product_in;
   end

   // status
   always_comb begin
      status.clr_done = (clr_cnt_ff == '1);
      status.upd_ok   = (req_position != '0) && (32'(req_position) <= 32'(LEAVES));
      status.is_root  = (node_ff == idx_type'(1));
      status.l_lt_r   = l_ff < r_ff;
      status.l_odd    = l_ff[0];
      status.r_odd    = r_ff[0];
      status.mul_done = mul_done;
   end

   assign rsp_product = product_ff;

endmodule

// ===== hw/rtl/rpms_ctrl.sv =====
`timescale 1ns / 1ps

module rpms_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_op,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rpms_pkg::cmd_type    cmd,
   input  rpms_pkg::status_type status
);
   import rpms_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel  = RD_LEFT_CHILD;
      cmd.mul_src = MS_CHILDREN;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (req_op) begin
                  state_in = ST_Q_TEST;
               end else if (status.upd_ok) begin
                  state_in = ST_U_WRITE;
               end
            end
         end
         ST_U_WRITE: begin
            cmd.wr_leaf = 1'b1;
            cmd.node_up = 1'b1;
            state_in    = ST_U_RDL;
         end
         ST_U_RDL: begin
            cmd.rd_sel = RD_LEFT_CHILD;
            state_in   = ST_U_RDR;
         end
         ST_U_RDR: begin
            cmd.rd_sel  = RD_RIGHT_CHILD;
            cmd.cap_opa = 1'b1;
            state_in    = ST_U_MUL;
         end
         ST_U_MUL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_src   = MS_CHILDREN;
            state_in      = ST_U_WAIT;
         end
         ST_U_WAIT: begin
            if (status.mul_done) begin
               cmd.wr_node = 1'b1;
               if (status.is_root) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.node_up = 1'b1;
                  state_in    = ST_U_RDL;
               end
            end
         end
         ST_Q_TEST: begin
            if (!status.l_lt_r) begin
               state_in = ST_Q_OUT;
            end else if (status.l_odd) begin
               cmd.rd_sel = RD_LOW;
               state_in   = ST_Q_LMUL;
            end else begin
               state_in = ST_Q_RCHK;
            end
         end
         ST_Q_LMUL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_src   = MS_ACC;
            cmd.l_inc     = 1'b1;
            state_in      = ST_Q_LWAIT;
         end
         ST_Q_LWAIT: begin
            if (status.mul_done) begin
               cmd.acc_load = 1'b1;
               state_in     = ST_Q_RCHK;
            end
         end
         ST_Q_RCHK: begin
            if (status.r_odd) begin
               cmd.rd_sel = RD_HIGH_DEC;
               cmd.r_dec  = 1'b1;
               state_in   = ST_Q_RMUL;
            end else begin
               state_in = ST_Q_SHIFT;
            end
         end
         ST_Q_RMUL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_src   = MS_ACC;
            state_in      = ST_Q_RWAIT;
         end
         ST_Q_RWAIT: begin
            if (status.mul_done) begin
               cmd.acc_load = 1'b1;
               state_in     = ST_Q_SHIFT;
            end
         end
         ST_Q_SHIFT: begin
            cmd.shift_lr = 1'b1;
            state_in     = ST_Q_TEST;
         end
         ST_Q_OUT: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output word register valid
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

endmodule

// ===== hw/rtl/range_product_mod_segment_tree_core.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake             word
// req       in         req_valid/req_stall   op, position, new_value, range_left, range_right
// rsp       out        rsp_valid/rsp_stall   product (one word per query, none per update)
//
// each modular product: 30 by 30 multiply, then reciprocal reduction.
// update: writes the leaf, then for each of the 10 levels above it reads both children and multiplies.
// query: per level tests the bounds, multiplies in each node used and shifts, at most 20 nodes.
// after reset a clearing pass writes ones to all 2048 nodes; req_stall is high until it is done.
// a finished query waits in its last state while the previous word is still stalled.

module range_product_mod_segment_tree_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_op,
   input  rpms_pkg::pos_type  req_position,
   input  rpms_pkg::val_type  req_new_value,
   input  rpms_pkg::pos_type  req_range_left,
   input  rpms_pkg::pos_type  req_range_right,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rpms_pkg::val_type  rsp_product
);
   import rpms_pkg::*;

   cmd_type    cmd;
   status_type status;

   rpms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   rpms_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_position    (req_position),
      .req_new_value   (req_new_value),
      .req_range_left  (req_range_left),
      .req_range_right (req_range_right),
      .rsp_product     (rsp_product)
   );

   // reduced product on every word
   a_product_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_product} < MODULUS))
      else $error("product not reduced");

   // a new word only comes from a query in progress
   a_word_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("word appeared while idle");

   // clearing pass holds off requests after reset
   a_clear_stalls: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request accepted during clearing pass");

   a_reset_no_word: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("word valid after reset");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import rpms_pkg::*;

   localparam logic [31:0] PRIME      = 32'd1000000007;
   localparam int          N_LEAF     = 1024;
   localparam int          N_SPAN     = 1024;
   localparam int          STALL_LIMIT = 20000;

   typedef enum logic {
      OP_SET   = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      op_type  op;
      pos_type position;
      val_type new_value;
      pos_type range_left;
      pos_type range_right;
   } word_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   logic    req_op;
   pos_type req_position;
   val_type req_new_value;
   pos_type req_range_left;
   pos_type req_range_right;
   logic    rsp_valid;
   logic    rsp_stall;
   val_type rsp_product;

   word_type    pending_words[$];
   logic [29:0] expected_products[$];
   logic [29:0] tree_model[2*N_SPAN];
   int          fail_count;
   int          idle_cycles;
   int          cycle_count;
   bit          stim_done;
   bit          req_taken;

   range_product_mod_segment_tree_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_position   (req_position),
      .req_new_value  (req_new_value),
      .req_range_left (req_range_left),
      .req_range_right(req_range_right),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_product    (rsp_product)
   );

   // clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic logic [29:0] mul_mod(logic [29:0] a, logic [29:0] b);
      logic [63:0] p;
      p = 64'(a) * 64'(b);
      return 30'(p % 64'(PRIME));
   endfunction

   // apply one word to the tree copy, returns 1 when a product is due
   function automatic bit tree_apply(word_type w, output logic [29:0] prod);
      int unsigned node, l, r, lo, hi;
      logic [29:0] acc;
      prod = '0;
      if (w.op == OP_SET) begin
         if (w.position < 1 || w.position > N_LEAF) return 0;
         node = N_SPAN - 1 + w.position;
         tree_model[node] = 30'(32'(w.new_value) % PRIME);
         while (node > 1) begin
            node = node >> 1;
            tree_model[node] = mul_mod(tree_model[2*node], tree_model[2*node+1]);
         end
         return 0;
      end
      lo = (w.range_left < 1) ? 1 : w.range_left;
      hi = (w.range_right > N_LEAF) ? N_LEAF : w.range_right;
      acc = 30'd1;
      if (lo <= hi) begin
         l = N_SPAN - 1 + lo;
         r = N_SPAN + hi;
         while (l < r) begin
            if (l[0]) begin
               acc = mul_mod(acc, tree_model[l]);
               l++;
            end
            if (r[0]) begin
               r--;
               acc = mul_mod(acc, tree_model[r]);
            end
            l = l >> 1;
            r = r >> 1;
         end
      end
      prod = acc;
      return 1;
   endfunction

   function automatic word_type set_word(int pos, logic [29:0] v);
      word_type w;
      w = '0;
      w.op = OP_SET;
      w.position = 11'(pos);
      w.new_value = v;
      w.range_left = 11'($urandom);
      w.range_right = 11'($urandom);
      return w;
   endfunction

   function automatic word_type query_word(int lo, int hi);
      word_type w;
      w = '0;
      w.op = OP_QUERY;
      w.position = 11'($urandom);
      w.new_value = 30'($urandom);
      w.range_left = 11'(lo);
      w.range_right = 11'(hi);
      return w;
   endfunction

   function automatic logic [29:0] rand_value();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 30'($urandom_range(0, 2));
      if (k == 1) return 30'(PRIME - 1 - $urandom_range(0, 3));
      if (k == 2) return 30'($urandom);
      return 30'($urandom_range(0, 1000000006));
   endfunction

   // stimulus
   initial begin
      int lo, k;
      for (int i = 0; i < 2*N_SPAN; i++) tree_model[i] = 30'd1;
      fail_count = 0;
      stim_done = 0;
      // directed: extremes, out of range positions, unreduced values, empty ranges
      pending_words.push_back(query_word(1, 1024));
      pending_words.push_back(set_word(1, 30'd1000000006));
      pending_words.push_back(set_word(1024, 30'd2));
      pending_words.push_back(set_word(512, 30'h3FFF_FFFF));
      pending_words.push_back(set_word(513, 30'd1000000007));
      pending_words.push_back(set_word(0, 30'd5));
      pending_words.push_back(set_word(1025, 30'd7));
      pending_words.push_back(set_word(2047, 30'd9));
      pending_words.push_back(set_word(2, 30'd0));
      pending_words.push_back(query_word(1, 1024));
      pending_words.push_back(query_word(0, 2047));
      pending_words.push_back(query_word(1, 1));
      pending_words.push_back(query_word(1024, 1024));
      pending_words.push_back(query_word(512, 513));
      pending_words.push_back(query_word(3, 1023));
      pending_words.push_back(query_word(600, 10));
      pending_words.push_back(query_word(2047, 0));
      pending_words.push_back(query_word(1025, 2047));
      pending_words.push_back(set_word(2, 30'd12345));
      pending_words.push_back(query_word(0, 3));
      // random: mostly valid updates and queries, some out of range
      for (int i = 0; i < 880; i++) begin
         k = $urandom_range(0, 19);
         if (k < 9) pending_words.push_back(set_word($urandom_range(1, 1024), rand_value()));
         else if (k == 9) pending_words.push_back(set_word($urandom, rand_value()));
         else if (k < 17) begin
            lo = $urandom_range(1, 1024);
            pending_words.push_back(query_word(lo, $urandom_range(lo, 1024)));
         end
         else pending_words.push_back(query_word($urandom, $urandom));
      end
      stim_done = 1;
   end

   // driver
   always @(negedge clock) begin
      word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_words.size() > 0 && ((cycle_count > 30000 && cycle_count < 60000)
                                          || $urandom_range(0, 99) >= 10)) begin
            w = pending_words.pop_front();
            req_valid <= 1'b1;
            req_op <= w.op;
            req_position <= w.position;
            req_new_value <= w.new_value;
            req_range_left <= w.range_left;
            req_range_right <= w.range_right;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= reset ? 1'b0 : ((cycle_count > 30000 && cycle_count < 60000) ? 1'b0
                                   : ($urandom_range(0, 99) < 10));
   end

   // monitor
   always @(posedge clock) begin
      word_type w;
      logic [29:0] prod;
      logic [29:0] want;
      bit moved;
      moved = 1'b0;
      cycle_count <= cycle_count + 1;
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            w.op = op_type'(req_op);
            w.position = req_position;
            w.new_value = req_new_value;
            w.range_left = req_range_left;
            w.range_right = req_range_right;
            if (tree_apply(w, prod)) expected_products.push_back(prod);
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (expected_products.size() == 0) begin
               $error("unexpected word: product actual %0d", rsp_product);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_products.pop_front();
               if (rsp_product !== want) begin
                  $error("product mismatch: expected %0d actual %0d", want, rsp_product);
                  fail_count <= fail_count + 1;
               end
            end
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // reset and end of run
   initial begin
      cycle_count = 0;
      idle_cycles = 0;
      req_taken = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = 1'b0;
      req_position = '0;
      req_new_value = '0;
      req_range_left = '0;
      req_range_right = '0;
      rsp_stall = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (stim_done && pending_words.size() == 0);
      @(posedge clock);
      while (req_valid) @(posedge clock);
      while (expected_products.size() > 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (fail_count == 0 && expected_products.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
